// ----- hdl/lbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the 3D segment clipper.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;  // one lane per cube face

  // Per-face flags, fixed before the divide
  typedef struct packed {
    logic big;   // |num| >= 4|den|: quotient far beyond 1.0
    logic tneg;  // quotient sign (num and den differ in sign)
    logic dpos;  // den > 0
    logic dneg;  // den < 0
    logic npos;  // num > 0
  } lbc_lane_t;

  // Control that travels with one segment through the face tests
  typedef struct packed {
    logic valid;
    logic vis;
  } lbc_ctl_t;

endpackage : lbc_pkg
`default_nettype wire

// ----- hdl/lbc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_div
// Six-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module lbc_div
  import lbc_pkg::*;
#(
  parameter int MW = 22,  // magnitude width of num and den
  parameter int QB = 18,  // quotient bits (= stages)
  parameter int IB = 2,   // integer quotient bits; the rest are fraction bits
  parameter int SW = 8    // sideband width
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [MW-1:0] num_i [NUM_LANES],
  input  wire logic [MW-1:0] den_i [NUM_LANES],
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QB-1:0]      quo_o [NUM_LANES],
  output logic [SW-1:0]      side_o
);

  logic          valid_q [QB];
  logic [MW-1:0] rem_q   [QB][NUM_LANES];
  logic [MW-1:0] den_q   [QB][NUM_LANES];
  logic [QB-1:0] quo_q   [QB][NUM_LANES];
  logic [SW-1:0] side_q  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K  = QB - 1 - j;
    // integer bits compare against a shifted den, fraction bits shift the rem
    localparam int SH = (j < IB) ? (IB - 1 - j) : 0;

    logic          v_in;
    logic [MW-1:0] r_in [NUM_LANES];
    logic [MW-1:0] d_in [NUM_LANES];
    logic [QB-1:0] q_in [NUM_LANES];
    logic [SW-1:0] s_in;
    logic [MW-1:0] r_d  [NUM_LANES];
    logic [QB-1:0] q_d  [NUM_LANES];

    if (j == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = num_i;
      assign d_in = den_i;
      assign s_in = side_i;
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_qz
        assign q_in[l] = '0;
      end
    end else begin : g_next
      assign v_in = valid_q[j-1];
      assign r_in = rem_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
      assign s_in = side_q[j-1];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [MW+QB-1:0] dsh;
      logic [MW+QB-1:0] rext;
      logic [MW+QB-1:0] diff;
      logic             ge;
      always_comb begin
        dsh  = {{QB{1'b0}}, d_in[l]} << SH;
        rext = (j < IB) ? {{QB{1'b0}}, r_in[l]} : {{(QB-1){1'b0}}, r_in[l], 1'b0};
        diff = rext - dsh;
        ge   = (rext >= dsh);
        r_d[l]    = ge ? diff[MW-1:0] : rext[MW-1:0];
        q_d[l]    = q_in[l];
        q_d[l][K] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= r_d;
      den_q[j]  <= d_in;
      quo_q[j]  <= q_d;
      side_q[j] <= s_in;
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule : lbc_div
`default_nettype wire

// ----- hdl/lbc_edge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_edge
// One axis of the clip test: min face then max face, one register stage.
// ----------------------------------------------------------------------------
module lbc_edge
  import lbc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int PW        = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lbc_ctl_t                             ctl_i,
  input  wire logic signed [FRAC_BITS+2:0]          t_enter_i,
  input  wire logic signed [FRAC_BITS+2:0]          t_leave_i,
  input  wire logic        [1:0][FRAC_BITS+1:0]     quo_i,
  input  wire lbc_lane_t   [1:0]                    lane_i,
  input  wire logic        [PW-1:0]                 pay_i,
  output lbc_ctl_t                                  ctl_o,
  output logic signed [FRAC_BITS+2:0]               t_enter_o,
  output logic signed [FRAC_BITS+2:0]               t_leave_o,
  output logic        [PW-1:0]                      pay_o
);

  localparam int QB = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 3;
  localparam logic [QB-1:0] ONE_Q = {1'b0, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [TW-1:0] OVER_T =
    {2'b00, 1'b1, {(FRAC_BITS-1){1'b0}}, 1'b1};

  lbc_ctl_t                ctl_d, ctl_q;
  logic signed [TW-1:0]    te_d, tl_d, te_q, tl_q;
  logic signed [TW-1:0]    tv [2];
  logic        [PW-1:0]    pay_q;

  // Quotient clamped to -1 .. 1.0+1: same decisions as the exact value
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (lane_i[b].tneg && (lane_i[b].big || (quo_i[b] != '0))) begin
        tv[b] = '1;
      end else if (lane_i[b].big || (quo_i[b] > ONE_Q)) begin
        tv[b] = OVER_T;
      end else begin
        tv[b] = signed'({1'b0, quo_i[b]});
      end
    end
  end

  always_comb begin
    ctl_d = ctl_i;
    te_d  = t_enter_i;
    tl_d  = t_leave_i;
    for (int b = 0; b < 2; b++) begin
      if (ctl_d.vis) begin
        if (lane_i[b].dpos) begin
          if (tv[b] > tl_d) begin
            ctl_d.vis = 1'b0;
          end else if (tv[b] > te_d) begin
            te_d = tv[b];
          end
        end else if (lane_i[b].dneg) begin
          if (tv[b] < te_d) begin
            ctl_d.vis = 1'b0;
          end else if (tv[b] < tl_d) begin
            tl_d = tv[b];
          end
        end else if (lane_i[b].npos) begin
          ctl_d.vis = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    te_q  <= te_d;
    tl_q  <= tl_d;
    pay_q <= pay_i;
  end

  assign ctl_o     = ctl_q;
  assign t_enter_o = te_q;
  assign t_leave_o = tl_q;
  assign pay_o     = pay_q;

endmodule : lbc_edge
`default_nettype wire

// ----- hdl/lbc_lerp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_lerp
// Clipped endpoints: product stage, then floor-shift, add and select.
// ----------------------------------------------------------------------------
module lbc_lerp
  import lbc_pkg::*;
#(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lbc_ctl_t                              ctl_i,
  input  wire logic signed [FRAC_BITS+2:0]           t_enter_i,
  input  wire logic signed [FRAC_BITS+2:0]           t_leave_i,
  input  wire logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  s_i,
  input  wire logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  e_i,
  input  wire logic [NUM_AXES-1:0][COORD_WIDTH:0]    d_i,
  output logic                                       valid_o,
  output logic                                       visible_o,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]       cs_o,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]       ce_o,
  output logic [FRAC_BITS:0]                         t_enter_o,
  output logic [FRAC_BITS:0]                         t_leave_o
);

  localparam int TW  = FRAC_BITS + 3;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PRW = DW + TW;
  localparam logic signed [TW-1:0] ONE_T = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0]   ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

  // product stage
  lbc_ctl_t                          ctl_q;
  logic signed [TW-1:0]              te_q, tl_q;
  logic signed [PRW-1:0]             pe_d [NUM_AXES];
  logic signed [PRW-1:0]             pl_d [NUM_AXES];
  logic signed [PRW-1:0]             pe_q [NUM_AXES];
  logic signed [PRW-1:0]             pl_q [NUM_AXES];
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] s_q, e_q;

  // output stage
  logic                                 vld_q, vis_q;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cs_d, ce_d, cs_q, ce_q;
  logic [FRAC_BITS:0]                   teo_d, tlo_d, teo_q, tlo_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pe_d[a] = signed'(d_i[a]) * t_enter_i;
      pl_d[a] = signed'(d_i[a]) * t_leave_i;
    end
  end

  always_comb begin
    logic signed [PRW-1:0] sx;
    logic signed [PRW-1:0] ps;
    logic signed [PRW-1:0] pl;
    for (int a = 0; a < NUM_AXES; a++) begin
      sx = PRW'(signed'(s_q[a]));
      ps = sx + (pe_q[a] >>> FRAC_BITS);
      pl = sx + (pl_q[a] >>> FRAC_BITS);
      cs_d[a] = s_q[a];
      ce_d[a] = e_q[a];
      if (ctl_q.vis && (te_q > '0)) begin
        cs_d[a] = ps[COORD_WIDTH-1:0];
      end
      if (ctl_q.vis && (tl_q < ONE_T)) begin
        ce_d[a] = pl[COORD_WIDTH-1:0];
      end
    end
    teo_d = ctl_q.vis ? te_q[FRAC_BITS:0] : '0;
    tlo_d = ctl_q.vis ? tl_q[FRAC_BITS:0] : ONE_U;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      vld_q <= 1'b0;
    end else begin
      ctl_q <= ctl_i;
      vld_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    te_q  <= t_enter_i;
    tl_q  <= t_leave_i;
    pe_q  <= pe_d;
    pl_q  <= pl_d;
    s_q   <= s_i;
    e_q   <= e_i;
    vis_q <= ctl_q.vis;
    cs_q  <= cs_d;
    ce_q  <= ce_d;
    teo_q <= teo_d;
    tlo_q <= tlo_d;
  end

  assign valid_o   = vld_q;
  assign visible_o = vis_q;
  assign cs_o      = cs_q;
  assign ce_o      = ce_q;
  assign t_enter_o = teo_q;
  assign t_leave_o = tlo_q;

endmodule : lbc_lerp
`default_nettype wire

// ----- hdl/line_segment_clipper_3d_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_segment_clipper_3d_top
// Liang-Barsky clipping of 3D segments against the cube [-1, 1]^3.
// ----------------------------------------------------------------------------
// Usage: drive a segment on the start/end ports and raise start; busy is
// always low, so one segment transfers on every cycle that start is high.
// Each segment yields exactly one result, marked by a one-cycle done_o strobe
// in input order. The receiver cannot stall the block; results must be taken
// on the cycle they appear. Sustained rate: one segment per clock. The
// pipeline is made of the face dividers, which resolve one quotient bit per
// stage (FRAC_BITS+2 stages), plus two input stages, three face-test stages
// (one per axis) and two stages for the endpoint multiply and add.
// ----------------------------------------------------------------------------
module line_segment_clipper_3d_top
  import lbc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_z_i,
  output logic                               done_o,
  output logic                               visible_o,
  output logic signed [COORD_WIDTH-1:0]      clip_start_x_o,
  output logic signed [COORD_WIDTH-1:0]      clip_start_y_o,
  output logic signed [COORD_WIDTH-1:0]      clip_start_z_o,
  output logic signed [COORD_WIDTH-1:0]      clip_end_x_o,
  output logic signed [COORD_WIDTH-1:0]      clip_end_y_o,
  output logic signed [COORD_WIDTH-1:0]      clip_end_z_o,
  output logic [FRAC_BITS:0]                 t_enter_o,
  output logic [FRAC_BITS:0]                 t_leave_o
);

  // Widths. NW holds the signed face distance (start - 1.0 and friends).
  localparam int DW  = COORD_WIDTH + 1;
  localparam int NW  = ((COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 1) + 2;
  localparam int QB  = FRAC_BITS + 2;
  localparam int TW  = FRAC_BITS + 3;
  localparam int LAT = FRAC_BITS + 9;
  localparam logic signed [NW-1:0] ONE_N = {{(NW-FRAC_BITS-1){1'b0}}, 1'b1,
                                            {FRAC_BITS{1'b0}}};
  localparam logic signed [TW-1:0] ONE_T = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0]   ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

  // Geometry carried alongside the math
  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] s;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] e;
    logic [NUM_AXES-1:0][DW-1:0]          d;
  } geom_t;

  typedef struct packed {
    lbc_lane_t [NUM_LANES-1:0] lane;
    geom_t                     geom;
  } side_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][QB-1:0] quo;
    side_t                        side;
  } ed_pay_t;

  // The pipeline never stalls; a transfer happens whenever start is high.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage A: register the segment, form delta and the face distances.
  // --------------------------------------------------------------------------
  logic                          va_q;
  logic signed [COORD_WIDTH-1:0] s_in [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] e_in [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s_q  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] e_q  [NUM_AXES];
  logic signed [DW-1:0]          d_q  [NUM_AXES];
  logic signed [NW-1:0]          nmin_q [NUM_AXES];  // -1.0 - s
  logic signed [NW-1:0]          nmax_q [NUM_AXES];  //  s - 1.0

  assign s_in[0] = start_x_i;
  assign s_in[1] = start_y_i;
  assign s_in[2] = start_z_i;
  assign e_in[0] = end_x_i;
  assign e_in[1] = end_y_i;
  assign e_in[2] = end_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s_q[a]    <= s_in[a];
      e_q[a]    <= e_in[a];
      d_q[a]    <= DW'(e_in[a]) - DW'(s_in[a]);
      nmin_q[a] <= -ONE_N - NW'(s_in[a]);
      nmax_q[a] <= NW'(s_in[a]) - ONE_N;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: per face, signs, magnitudes and the far-out check.
  // Even lanes are the min faces (den = d), odd lanes the max faces (den = -d).
  // --------------------------------------------------------------------------
  logic          vb_q;
  logic [NW-1:0] nabs_d [NUM_LANES];
  logic [NW-1:0] dabs_d [NUM_LANES];
  logic [NW-1:0] nabs_q [NUM_LANES];
  logic [NW-1:0] dabs_q [NUM_LANES];
  side_t         side_d, side_q;

  always_comb begin
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] den;
    for (int l = 0; l < NUM_LANES; l++) begin
      num = l[0] ? nmax_q[l/2] : nmin_q[l/2];
      den = l[0] ? -NW'(d_q[l/2]) : NW'(d_q[l/2]);
      nabs_d[l] = num[NW-1] ? NW'(-num) : NW'(num);
      dabs_d[l] = den[NW-1] ? NW'(-den) : NW'(den);
      side_d.lane[l].npos = !num[NW-1] && (num != '0);
      side_d.lane[l].dpos = !den[NW-1] && (den != '0);
      side_d.lane[l].dneg = den[NW-1];
      side_d.lane[l].tneg = num[NW-1] ^ den[NW-1];
      side_d.lane[l].big  = ({2'b00, nabs_d[l]} >= {dabs_d[l], 2'b00});
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      side_d.geom.s[a] = s_q[a];
      side_d.geom.e[a] = e_q[a];
      side_d.geom.d[a] = d_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nabs_q <= nabs_d;
    dabs_q <= dabs_d;
    side_q <= side_d;
  end

  // --------------------------------------------------------------------------
  // Face dividers: |num| * 2^FRAC_BITS / |den|, FRAC_BITS+2 quotient bits.
  // Far-out quotients are flagged by 'big' instead of being computed.
  // --------------------------------------------------------------------------
  logic          dv_valid;
  logic [QB-1:0] dv_quo [NUM_LANES];
  side_t         dv_side;

  lbc_div #(
    .MW (NW),
    .QB (QB),
    .IB (QB - FRAC_BITS),
    .SW ($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vb_q),
    .num_i   (nabs_q),
    .den_i   (dabs_q),
    .side_i  (side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Face tests in order x, y, z; entry t starts at 0, exit t at 1.0.
  // --------------------------------------------------------------------------
  lbc_ctl_t             ectl [NUM_AXES+1];
  logic signed [TW-1:0] ete  [NUM_AXES+1];
  logic signed [TW-1:0] etl  [NUM_AXES+1];
  ed_pay_t              epay [NUM_AXES+1];

  always_comb begin
    ectl[0].valid = dv_valid;
    ectl[0].vis   = 1'b1;
    ete[0]        = '0;
    etl[0]        = ONE_T;
    for (int l = 0; l < NUM_LANES; l++) begin
      epay[0].quo[l] = dv_quo[l];
    end
    epay[0].side = dv_side;
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    lbc_edge #(
      .FRAC_BITS (FRAC_BITS),
      .PW        ($bits(ed_pay_t))
    ) u_edge (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ectl[a]),
      .t_enter_i (ete[a]),
      .t_leave_i (etl[a]),
      .quo_i     (epay[a].quo[2*a+1:2*a]),
      .lane_i    (epay[a].side.lane[2*a+1:2*a]),
      .pay_i     (epay[a]),
      .ctl_o     (ectl[a+1]),
      .t_enter_o (ete[a+1]),
      .t_leave_o (etl[a+1]),
      .pay_o     (epay[a+1])
    );
  end

  // --------------------------------------------------------------------------
  // Endpoint interpolation and output register.
  // --------------------------------------------------------------------------
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cs, ce;

  lbc_lerp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ectl[NUM_AXES]),
    .t_enter_i (ete[NUM_AXES]),
    .t_leave_i (etl[NUM_AXES]),
    .s_i       (epay[NUM_AXES].side.geom.s),
    .e_i       (epay[NUM_AXES].side.geom.e),
    .d_i       (epay[NUM_AXES].side.geom.d),
    .valid_o   (done_o),
    .visible_o (visible_o),
    .cs_o      (cs),
    .ce_o      (ce),
    .t_enter_o (t_enter_o),
    .t_leave_o (t_leave_o)
  );

  assign clip_start_x_o = signed'(cs[0]);
  assign clip_start_y_o = signed'(cs[1]);
  assign clip_start_z_o = signed'(cs[2]);
  assign clip_end_x_o   = signed'(ce[0]);
  assign clip_end_y_o   = signed'(ce[1]);
  assign clip_end_z_o   = signed'(ce[2]);

`ifndef SYNTH
  // Every transfer yields its result strobe.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result strobe missing at fixed latency");

  // No strobe without a matching earlier transfer.
  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##LAT (done_o |-> $past(start && !busy, LAT)))
    else $error("result strobe without a transfer");

  // Visible segments keep entry <= exit <= 1.0.
  a_t_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && visible_o) |-> (t_enter_o <= t_leave_o && t_leave_o <= ONE_U))
    else $error("entry/exit parameters out of order");

  // Rejected segments report the default parameters.
  a_reject_t : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |-> (t_enter_o == '0 && t_leave_o == ONE_U))
    else $error("rejected segment with clipped parameters");
`endif

endmodule : line_segment_clipper_3d_top
`default_nettype wire

// ----- tb/sv/line_segment_clipper_3d_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_clipper_3d_top_test
// Checks the 3D segment clipper against an in-bench Liang-Barsky predictor:
// directed edge-case segments, then random segments with random start gaps.
// ----------------------------------------------------------------------------
module line_segment_clipper_3d_top_test;
  import lbc_pkg::*;

  localparam int FB      = 16;
  localparam int CW      = 20;
  localparam int LATENCY = FB + 9;
  localparam int WDOG    = 2000;
  localparam longint ONE = longint'(1) << FB;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic         vis;
    coord_t       cs[3];
    coord_t       ce[3];
    logic [FB:0]  te;
    logic [FB:0]  tl;
  } clip_res_t;

  // One face test; returns 0 when the segment is rejected.
  function automatic bit face_test(longint den, longint num, ref longint te, ref longint tl);
    longint t;
    if (den > 0) begin
      t = (num * ONE) / den;
      if (t > tl) return 0;
      if (t > te) te = t;
    end else if (den < 0) begin
      t = (num * ONE) / den;
      if (t < te) return 0;
      if (t < tl) tl = t;
    end else if (num > 0) begin
      return 0;
    end
    return 1;
  endfunction

  // start + floor(delta * t / 2^FB)
  function automatic longint interp(longint s, longint d, longint t);
    longint p, q;
    p = d * t;
    q = p / ONE;
    if (p < 0 && (p % ONE) != 0) q -= 1;
    return s + q;
  endfunction

  function automatic clip_res_t clip_segment(coord_t sp[3], coord_t ep[3]);
    clip_res_t r;
    longint s[3], d[3];
    longint te, tl;
    bit vis;
    te = 0;
    tl = ONE;
    vis = 1;
    for (int i = 0; i < 3; i++) begin
      s[i] = sp[i];
      d[i] = longint'(ep[i]) - s[i];
      r.cs[i] = sp[i];
      r.ce[i] = ep[i];
    end
    for (int i = 0; i < 3 && vis; i++) begin
      if (!face_test(d[i], -ONE - s[i], te, tl)) vis = 0;
      else if (!face_test(-d[i], s[i] - ONE, te, tl)) vis = 0;
    end
    if (vis) begin
      for (int i = 0; i < 3; i++) begin
        if (tl < ONE) r.ce[i] = coord_t'(interp(s[i], d[i], tl));
        if (te > 0) r.cs[i] = coord_t'(interp(s[i], d[i], te));
      end
    end else begin
      te = 0;
      tl = ONE;
    end
    r.vis = vis;
    r.te = te[FB:0];
    r.tl = tl[FB:0];
    return r;
  endfunction

  class clip_scoreboard;
    clip_res_t pending[$];
    int errors;
    int n_checked;
    int n_visible;

    function void note_segment(coord_t sp[3], coord_t ep[3]);
      pending.insert(pending.size(), clip_segment(sp, ep));
    endfunction

    function void check_result(clip_res_t act);
      clip_res_t exp;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with no segment pending", $time);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.vis) n_visible++;
      if (act.vis !== exp.vis) begin
        $display("%0t: visible exp %0d act %0d", $time, exp.vis, act.vis);
        errors++;
      end
      for (int i = 0; i < 3; i++) begin
        if (act.cs[i] !== exp.cs[i]) begin
          $display("%0t: clip_start[%0d] exp %0d act %0d", $time, i, exp.cs[i], act.cs[i]);
          errors++;
        end
        if (act.ce[i] !== exp.ce[i]) begin
          $display("%0t: clip_end[%0d] exp %0d act %0d", $time, i, exp.ce[i], act.ce[i]);
          errors++;
        end
      end
      if (act.te !== exp.te) begin
        $display("%0t: t_enter exp %0d act %0d", $time, exp.te, act.te);
        errors++;
      end
      if (act.tl !== exp.tl) begin
        $display("%0t: t_leave exp %0d act %0d", $time, exp.tl, act.tl);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 0;
  logic   rst_ni = 0;
  logic   start = 0;
  logic   busy;
  coord_t sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
  logic   done_o, visible_o;
  coord_t csx, csy, csz, cex, cey, cez;
  logic [FB:0] t_enter_o, t_leave_o;

  clip_scoreboard sb = new();
  int idle_cycles;    // watchdog: cycles with no transfer either way
  bit timed_out;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  line_segment_clipper_3d_top #(.FRAC_BITS(FB), .COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .done_o, .visible_o,
    .clip_start_x_o(csx), .clip_start_y_o(csy), .clip_start_z_o(csz),
    .clip_end_x_o(cex), .clip_end_y_o(cey), .clip_end_z_o(cez),
    .t_enter_o, .t_leave_o
  );

  // Results are taken at the rising edge; the receiver cannot stall.
  always @(posedge clk_i) begin
    clip_res_t r;
    if (rst_ni) begin
      if (done_o) begin
        r.vis = visible_o;
        r.cs = '{csx, csy, csz};
        r.ce = '{cex, cey, cez};
        r.te = t_enter_o;
        r.tl = t_leave_o;
        sb.check_result(r);
        idle_cycles <= 0;
      end else if (!(start && !busy)) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        idle_cycles <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG && !timed_out) begin
      timed_out = 1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one segment with an optional random lead-in gap; hold start until transfer.
  task automatic send_segment(coord_t s0, coord_t s1, coord_t s2,
                              coord_t e0, coord_t e1, coord_t e2, bit gaps);
    int gap;
    gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk_i);
    end
    sx <= s0; sy <= s1; sz <= s2;
    ex <= e0; ey <= e1; ez <= e2;
    start <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_segment('{s0, s1, s2}, '{e0, e1, e2});
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    start <= 0;
    @(negedge clk_i);
  endtask

  // Coordinate near the cube: mostly within +-2.0, sometimes any pattern.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return coord_t'($urandom);
      1:       return coord_t'($urandom_range(0, 2) * ONE - ONE);  // -1, 0, +1
      default: return coord_t'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
    endcase
  endfunction

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ZR   = '0;
  localparam coord_t LSB  = coord_t'(1);
  localparam coord_t MLSB = coord_t'(-1);
  localparam coord_t P1   = coord_t'(ONE);
  localparam coord_t M1   = coord_t'(-ONE);
  localparam coord_t P2   = coord_t'(2 * ONE);
  localparam coord_t M2   = coord_t'(-2 * ONE);
  localparam coord_t P3   = coord_t'(3 * ONE);
  localparam coord_t M3   = coord_t'(-3 * ONE);
  localparam coord_t HALF = coord_t'(ONE / 2);

  initial begin
    coord_t a, b, c;
    idle_cycles = 0;
    timed_out = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, faces, zero directions, degenerate points.
    send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0);
    send_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0);
    send_segment(ZR, ZR, ZR, ZR, ZR, ZR, 1'b0);           // point inside
    send_segment(HALF, -HALF, HALF, HALF, -HALF, HALF, 1'b0);
    send_segment(CMAX, ZR, ZR, CMAX, ZR, ZR, 1'b0);       // point outside
    send_segment(P2, ZR, ZR, P2, HALF, ZR, 1'b0);         // zero dx, outside
    send_segment(ZR, M2, ZR, HALF, M2, ZR, 1'b0);         // zero dy, outside
    send_segment(ZR, ZR, P2, ZR, HALF, P2, 1'b0);         // zero dz, outside
    send_segment(M1, M1, M1, P1, P1, P1, 1'b0);           // exactly on corners
    send_segment(M2, ZR, ZR, P2, ZR, ZR, 1'b0);           // clipped both ends
    send_segment(ZR, M2, ZR, ZR, P2, ZR, 1'b0);
    send_segment(ZR, ZR, M2, ZR, ZR, P2, 1'b0);
    send_segment(P2, HALF, HALF, M2, -HALF, HALF, 1'b0);
    send_segment(ZR, ZR, ZR, P3, P3, M3, 1'b0);           // exit only
    send_segment(M3, P3, ZR, ZR, ZR, ZR, 1'b0);           // entry only
    send_segment(P2, P2, ZR, P3, M1, ZR, 1'b0);           // misses the cube
    send_segment(M1, P1, ZR, P1, P1, ZR, 1'b0);           // along a face
    send_segment(CMIN, ZR, ZR, CMAX, LSB, MLSB, 1'b0);
    send_segment(MLSB, ZR, ZR, LSB, ZR, ZR, 1'b0);
    send_segment(P1 + LSB, ZR, ZR, P1 - LSB, ZR, ZR, 1'b0);
    stop_sending();

    // Pause until every pending result has come.
    while (sb.pending.size() != 0) @(negedge clk_i);

    // Random: mostly segments crossing the cube region, some raw bits.
    for (int n = 0; n < 600; n++) begin
      a = rand_coord(); b = rand_coord(); c = rand_coord();
      if ($urandom_range(0, 9) == 0)
        send_segment(a, b, c, a, b, c, 1'b1);
      else if (n >= 200 && n < 300)     // back-to-back stretch
        send_segment(a, b, c, rand_coord(), rand_coord(), rand_coord(), 1'b0);
      else
        send_segment(a, b, c, rand_coord(), rand_coord(), rand_coord(), 1'b1);
    end
    stop_sending();

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);

    $display("Checked %0d results, %0d visible segments, random gaps and bursts.",
             sb.n_checked, sb.n_visible);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
